FILE: hw/rtl/radial_tukey_sample_weight_macros.svh
// Assertion macros for the radial Tukey sample weight block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RADIAL_TUKEY_SAMPLE_WEIGHT_MACROS_SVH
`define RADIAL_TUKEY_SAMPLE_WEIGHT_MACROS_SVH

// checked only out of reset
`define RTSW_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define RTSW_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rtsw_pkg.sv
// Shared types and constants for the radial Tukey sample weight block.
// No dependencies.
`timescale 1ns / 1ps
package rtsw_pkg;

  localparam int COORD_DIMS = 3;

  // register indexes
  localparam logic [1:0] CFG_TAPER_START  = 2'd0;
  localparam logic [1:0] CFG_TAPER_END    = 2'd1;
  localparam logic [1:0] CFG_FLOOR_HEIGHT = 2'd2;

  localparam logic [15:0] HEIGHT_ONE = 16'd32768;

  // Taylor coefficients of cos(pi*u), Q3.30 scaled
  localparam logic [32:0] COS_C1 = 33'd5298703516;
  localparam logic [32:0] COS_C2 = 33'd4358008962;
  localparam logic [32:0] COS_C3 = 33'd1433727481;
  localparam logic [32:0] COS_C4 = 33'd252684340;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  localparam int SQ_STAGES  = 8;   // two root bits per stage
  localparam int DIV_STEPS  = 17;  // quotient bits
  localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;

  typedef enum logic [1:0] {RG_ONE, RG_TAPER, RG_ZERO} region_t;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               coord_valid;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
  } out_t;

  typedef struct packed {
    logic [15:0] taper_start;
    logic [15:0] taper_end;
    logic [15:0] height;      // already saturated to one
  } cfg_t;

  typedef struct packed {
    logic               coord_valid;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    region_t            region;
  } pay_t;

  typedef struct packed {
    logic [31:0] sum;
    pay_t        pay;
  } rad_t;

  typedef struct packed {
    logic [15:0] root;
    pay_t        pay;
  } rt_t;

  typedef struct packed {
    logic [16:0] phase;
    pay_t        pay;
  } ph_t;

endpackage

FILE: hw/rtl/rtsw_front.sv
// Front stages: coordinate squares, squared radius and region decision.
// Depends on rtsw_pkg.
`timescale 1ns / 1ps
module rtsw_front import rtsw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  in_t  in_word,
  output logic in_rdy,
  input  cfg_t cfg,
  output logic out_vld,
  output rad_t out_word,
  input  logic out_rdy
);

  logic [1:0] v_r;
  logic [2:0] adv;
  logic [30:0] xx_r, yy_r, zz_r;
  logic [31:0] st_sq_r, en_sq_r;
  pay_t p0_r;
  rad_t s1_r;

  logic signed [31:0] xs, ys, zs;
  logic [31:0] sum;
  rad_t s1_nxt;

  assign adv[2] = out_rdy;
  assign adv[1] = !v_r[1] || adv[2];
  assign adv[0] = !v_r[0] || adv[1];
  assign in_rdy = adv[0];

  always_comb begin
    xs = in_word.coord_x * in_word.coord_x;
    ys = in_word.coord_y * in_word.coord_y;
    zs = (COORD_DIMS > 2) ? in_word.coord_z * in_word.coord_z : 32'sd0;
  end

  always_comb begin
    sum = {1'b0, xx_r} + {1'b0, yy_r} + {1'b0, zz_r};
    s1_nxt.sum = sum;
    s1_nxt.pay = p0_r;
    if (sum > en_sq_r) begin
      s1_nxt.pay.region = RG_ZERO;
    end else if (sum > st_sq_r) begin
      s1_nxt.pay.region = RG_TAPER;
    end else begin
      s1_nxt.pay.region = RG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_vld;
      if (adv[1]) v_r[1] <= v_r[0];
    end
  end

  // config must be held static while words are in flight; the block does not enforce it
  always_ff @(posedge clk) begin
    st_sq_r <= 32'(cfg.taper_start) * 32'(cfg.taper_start);
    en_sq_r <= 32'(cfg.taper_end) * 32'(cfg.taper_end);
    if (adv[0]) begin
      xx_r <= xs[30:0];
      yy_r <= ys[30:0];
      zz_r <= zs[30:0];
      p0_r.coord_valid <= in_word.coord_valid;
      p0_r.sample_re   <= in_word.sample_re;
      p0_r.sample_im   <= in_word.sample_im;
      p0_r.region      <= RG_ONE;
    end
    if (adv[1]) s1_r <= s1_nxt;
  end

  assign out_vld  = v_r[1];
  assign out_word = s1_r;

endmodule

FILE: hw/rtl/rtsw_sqrt.sv
// Pipelined digit-by-digit integer square root of the squared radius.
// Depends on rtsw_pkg.
`timescale 1ns / 1ps
module rtsw_sqrt import rtsw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  rad_t in_word,
  output logic in_rdy,
  output logic out_vld,
  output rt_t  out_word,
  input  logic out_rdy
);

  logic [SQ_STAGES-1:0] v_r;
  logic [SQ_STAGES:0]   adv;
  logic [17:0] rem_r  [SQ_STAGES];
  logic [15:0] root_r [SQ_STAGES];
  logic [31:0] sum_r  [SQ_STAGES];
  pay_t        pay_r  [SQ_STAGES];

  assign adv[SQ_STAGES] = out_rdy;
  assign in_rdy = adv[0];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    logic [17:0] rem_i, rem_o;
    logic [15:0] root_i, root_o;
    logic [31:0] sum_i;
    pay_t        pay_i;
    logic [18:0] t;
    logic [17:0] trial;

    assign adv[k] = !v_r[k] || adv[k+1];

    if (k == 0) begin : g_head
      assign rem_i  = '0;
      assign root_i = '0;
      assign sum_i  = in_word.sum;
      assign pay_i  = in_word.pay;
    end else begin : g_body
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign sum_i  = sum_r[k-1];
      assign pay_i  = pay_r[k-1];
    end

    always_comb begin
      rem_o  = rem_i;
      root_o = root_i;
      t      = '0;
      trial  = '0;
      for (int j = 0; j < 2; j++) begin
        t     = {rem_o[16:0], sum_i[2*(15-(2*k+j)) +: 2]};
        trial = {root_o, 2'b01};
        if (t >= {1'b0, trial}) begin
          rem_o  = 18'(t - {1'b0, trial});
          root_o = {root_o[14:0], 1'b1};
        end else begin
          rem_o  = t[17:0];
          root_o = {root_o[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_r[k]  <= rem_o;
        root_r[k] <= root_o;
        sum_r[k]  <= sum_i;
        pay_r[k]  <= pay_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        if (adv[k]) v_r[k] <= (k == 0) ? in_vld : v_r[k-1];
      end
    end
  end

  assign out_vld       = v_r[SQ_STAGES-1];
  assign out_word.root = root_r[SQ_STAGES-1];
  assign out_word.pay  = pay_r[SQ_STAGES-1];

endmodule

FILE: hw/rtl/rtsw_div.sv
// Pipelined restoring divider: taper phase (r - start) * 2^16 / (end - start).
// Depends on rtsw_pkg.
`timescale 1ns / 1ps
module rtsw_div import rtsw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  rt_t  in_word,
  output logic in_rdy,
  input  cfg_t cfg,
  output logic out_vld,
  output ph_t  out_word,
  input  logic out_rdy
);

  localparam int NS = DIV_STAGES + 1;

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;
  logic [15:0] rem_r [NS];
  logic [16:0] quo_r [NS];
  logic        d0_r  [NS];
  pay_t        pay_r [NS];

  logic [15:0] den;
  logic [15:0] rdiff;

  // only meaningful in the taper region, where end > start
  assign den   = 16'(cfg.taper_end - cfg.taper_start);
  assign rdiff = 16'(in_word.root - cfg.taper_start);

  assign adv[NS] = out_rdy;
  assign in_rdy  = adv[0];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [15:0] rem_o;
    logic [16:0] quo_o;
    logic        d0_o;
    pay_t        pay_o;
    logic [16:0] t;

    assign adv[k] = !v_r[k] || adv[k+1];

    if (k == 0) begin : g_prep
      always_comb begin
        t     = '0;
        rem_o = {1'b0, rdiff[15:1]};
        quo_o = '0;
        d0_o  = rdiff[0];
        pay_o = in_word.pay;
      end
    end else begin : g_step
      always_comb begin
        rem_o = rem_r[k-1];
        quo_o = quo_r[k-1];
        d0_o  = d0_r[k-1];
        pay_o = pay_r[k-1];
        t     = '0;
        for (int j = 0; j < 2; j++) begin
          if (2*(k-1)+j < DIV_STEPS) begin
            // first step brings down the low bit of the distance, then zeros
            t = {rem_o, (2*(k-1)+j == 0) ? d0_o : 1'b0};
            if (t >= {1'b0, den}) begin
              rem_o = 16'(t - {1'b0, den});
              quo_o = {quo_o[15:0], 1'b1};
            end else begin
              rem_o = t[15:0];
              quo_o = {quo_o[15:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_r[k] <= rem_o;
        quo_r[k] <= quo_o;
        d0_r[k]  <= d0_o;
        pay_r[k] <= pay_o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) v_r[k] <= (k == 0) ? in_vld : v_r[k-1];
      end
    end
  end

  assign out_vld        = v_r[NS-1];
  assign out_word.phase = quo_r[NS-1];
  assign out_word.pay   = pay_r[NS-1];

endmodule

FILE: hw/rtl/rtsw_cos.sv
// Cosine taper weight by Horner stages, then weighting and rounding.
// Depends on rtsw_pkg.
`timescale 1ns / 1ps
module rtsw_cos import rtsw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  ph_t  in_word,
  output logic in_rdy,
  input  cfg_t cfg,
  output logic out_vld,
  output out_t out_word,
  input  logic out_rdy
);

  localparam int NS = 9;

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;
  pay_t          pay_r [NS];

  logic [28:0] w_r [5];
  logic        neg_r [5];
  logic [32:0] p1_r, p2_r, p3_r;
  logic [30:0] cmag_r;
  logic signed [50:0] m5_r;
  logic [30:0] wt_r;
  logic signed [47:0] pre_r, pim_r;
  out_t out_r;

  logic [16:0] ph;
  logic [15:0] u;
  logic        neg;
  logic [31:0] usq;
  logic [61:0] m1, m2, m3, m4;
  logic signed [32:0] c4;
  logic signed [32:0] cs;
  logic [16:0] hd, hs;
  logic signed [50:0] m5, acc;
  logic [30:0] wt;
  logic signed [31:0] we;
  logic signed [47:0] mre, mim;
  logic signed [17:0] qre, qim;

  assign adv[NS] = out_rdy;
  assign in_rdy  = adv[0];
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end

  // fold the phase onto the first quarter period
  always_comb begin
    ph = in_word.phase;
    if (ph <= 17'd32768) begin
      u   = ph[15:0];
      neg = 1'b0;
    end else if (ph > 17'd65536) begin
      u   = '0;
      neg = 1'b1;
    end else begin
      u   = 16'(17'd65536 - ph);
      neg = 1'b1;
    end
    usq = 32'(u) * 32'(u);
  end

  always_comb begin
    m1 = {29'b0, COS_C4} * {33'b0, w_r[0]};
    m2 = {29'b0, p1_r} * {33'b0, w_r[1]};
    m3 = {29'b0, p2_r} * {33'b0, w_r[2]};
    m4 = {29'b0, p3_r} * {33'b0, w_r[3]};
    c4 = $signed({2'b0, ONE_Q30}) - $signed({1'b0, m4[61:30]});
  end

  always_comb begin
    // sign travels with the magnitude held in stage 4
    cs  = neg_r[4] ? -$signed({2'b0, cmag_r}) : $signed({2'b0, cmag_r});
    hd  = 17'(17'd32768 - {1'b0, cfg.height});
    hs  = 17'(17'd32768 + {1'b0, cfg.height});
    m5  = $signed({1'b0, hd}) * cs;
    acc = $signed({4'b0, hs, 30'b0}) + m5_r;
    unique case (pay_r[5].region)
      RG_ONE:   wt = ONE_Q30;
      RG_TAPER: wt = acc[46:16];
      default:  wt = '0;
    endcase
    we  = $signed({1'b0, wt_r});
    mre = pay_r[6].sample_re * we + 48'sh0000_2000_0000;
    mim = pay_r[6].sample_im * we + 48'sh0000_2000_0000;
    qre = pre_r[47:30];
    qim = pim_r[47:30];
  end

  function automatic logic signed [15:0] sat16(input logic signed [17:0] q);
    if (q > 18'sd32767) begin
      sat16 = 16'sd32767;
    end else if (q < -18'sd32768) begin
      sat16 = -16'sd32768;
    end else begin
      sat16 = q[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      w_r[0]   <= usq[30:2];
      neg_r[0] <= neg;
      pay_r[0] <= in_word.pay;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) pay_r[k] <= pay_r[k-1];
    end
    for (int k = 1; k < 5; k++) begin
      if (adv[k]) neg_r[k] <= neg_r[k-1];
    end
    for (int k = 1; k < 5; k++) begin
      if (adv[k]) w_r[k] <= w_r[k-1];
    end
    if (adv[1]) p1_r <= 33'(COS_C3 - {1'b0, m1[61:30]});
    if (adv[2]) p2_r <= 33'(COS_C2 - {1'b0, m2[61:30]});
    if (adv[3]) p3_r <= 33'(COS_C1 - {1'b0, m3[61:30]});
    if (adv[4]) cmag_r <= c4[32] ? 31'd0 : c4[30:0];
    if (adv[5]) m5_r <= m5;
    if (adv[6]) wt_r <= wt;
    if (adv[7]) begin
      pre_r <= mre;
      pim_r <= mim;
    end
    if (adv[8]) begin
      out_r.out_re <= pay_r[7].coord_valid ? sat16(qre) : 16'sd0;
      out_r.out_im <= pay_r[7].coord_valid ? sat16(qim) : 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) v_r[k] <= (k == 0) ? in_vld : v_r[k-1];
      end
    end
  end

  assign out_vld  = v_r[NS-1];
  assign out_word = out_r;

endmodule

FILE: hw/rtl/radial_tukey_sample_weight.sv
// Top level of the radial Tukey sample weight block: config registers and
// the four pipeline sections. Depends on rtsw_pkg and the rtsw_* modules.
//
//   channel  ports                             word
//   in       in_valid / in_ready / in_data     in_t  (coords, flag, sample)
//   out      out_valid / out_ready / out_data  out_t (weighted sample)
//   cfg      cfg_valid / cfg_ready             cfg_index, cfg_data
//
// One word per cycle sustained while out_ready is high; pipeline stages: 2 front,
// 8 square root, 10 divider, 9 cosine and weighting.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up and a stall loses nothing.
// Synchronous reset clears the valid bits and sets the config to its defaults; no clearing pass.
`timescale 1ns / 1ps
`include "radial_tukey_sample_weight_macros.svh"
module radial_tukey_sample_weight import rtsw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] start_r, end_r, height_r;
  cfg_t cfg;

  logic f_vld, f_rdy, s_vld, s_rdy, d_vld, d_rdy;
  rad_t f_word;
  rt_t  s_word;
  ph_t  d_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= 16'hFFFF;
      end_r    <= 16'hFFFF;
      height_r <= HEIGHT_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TAPER_START:  start_r  <= cfg_data;
        CFG_TAPER_END:    end_r    <= cfg_data;
        CFG_FLOOR_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.taper_start = start_r;
    cfg.taper_end   = end_r;
    cfg.height      = (height_r > HEIGHT_ONE) ? HEIGHT_ONE : height_r;
  end

  rtsw_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_vld(in_valid), .in_word(in_data), .in_rdy(in_ready),
    .cfg(cfg),
    .out_vld(f_vld), .out_word(f_word), .out_rdy(f_rdy)
  );

  rtsw_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n),
    .in_vld(f_vld), .in_word(f_word), .in_rdy(f_rdy),
    .out_vld(s_vld), .out_word(s_word), .out_rdy(s_rdy)
  );

  rtsw_div u_div (
    .clk(clk), .rst_n(rst_n),
    .in_vld(s_vld), .in_word(s_word), .in_rdy(s_rdy),
    .cfg(cfg),
    .out_vld(d_vld), .out_word(d_word), .out_rdy(d_rdy)
  );

  rtsw_cos u_cos (
    .clk(clk), .rst_n(rst_n),
    .in_vld(d_vld), .in_word(d_word), .in_rdy(d_rdy),
    .cfg(cfg),
    .out_vld(out_valid), .out_word(out_data), .out_rdy(out_ready)
  );

  `RTSW_CHK_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")
  `RTSW_CHK(a_ready_chain, (out_ready || !out_valid) |-> in_ready, "pipeline ready chain broken")

endmodule

FILE: dv/tb_radial_tukey_sample_weight.sv
// Testbench for radial_tukey_sample_weight: random and directed k-space samples
// checked against a bit-exact Tukey weight predictor. Depends on rtsw_pkg.
`timescale 1ns / 1ps
module tb_radial_tukey_sample_weight;
  import rtsw_pkg::*;

  localparam int RUN_ITEMS = 550;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  radial_tukey_sample_weight dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [15:0] start_r, end_r, height_r;

  in_t pending_q[$];
  out_t weighted_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 30;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint cos_mag(longint u);
    longint w, p, c;
    w = (u * u) >>> 2;
    p = 64'd252684340;
    p = 64'd1433727481 - ((p * w) >>> 30);
    p = 64'd4358008962 - ((p * w) >>> 30);
    p = 64'd5298703516 - ((p * w) >>> 30);
    c = 64'd1073741824 - ((p * w) >>> 30);
    return (c < 0) ? 0 : c;
  endfunction

  function automatic logic [15:0] scale_sample(longint s, longint wq);
    longint q;
    q = (s * wq + (64'sd1 <<< 29)) >>> 30;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic out_t tukey_weight(in_t it);
    longint x, y, z, sum, st, en, r, p, h, c, wq, u;
    out_t res;
    x = it.coord_x; y = it.coord_y; z = it.coord_z;
    sum = x * x + y * y;
    if (COORD_DIMS > 2) sum += z * z;
    st = start_r; en = end_r;
    if (sum > en * en) begin
      wq = 0;
    end else if (sum > st * st) begin
      r = int_root(sum);
      p = ((r - st) <<< 16) / (en - st);
      h = (height_r > HEIGHT_ONE) ? 32768 : height_r;
      if (p <= 32768) begin
        c = cos_mag(p);
      end else begin
        u = (p > 65536) ? 0 : 65536 - p;
        c = -cos_mag(u);
      end
      wq = ((32768 + h) * 64'sd1073741824 + (32768 - h) * c) >>> 16;
    end else begin
      wq = 64'sd1073741824;
    end
    res = '0;
    if (it.coord_valid) begin
      res.out_re = scale_sample(it.sample_re, wq);
      res.out_im = scale_sample(it.sample_im, wq);
    end
    return res;
  endfunction

  // driver: bursts with gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        weighted_q.push_back(tukey_weight(in_data));
        void'(pending_q.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus the long hold-off
  int stall_mode = 0, mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_off) out_ready <= 1'b0;
    else if (stall_mode == 0) out_ready <= 1'b1;
    else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 3) == 0);
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (weighted_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        exp_w = weighted_q.pop_front();
        if (exp_w.out_re !== out_data.out_re) begin
          $display("%0t: out_re expected %0d actual %0d", $time,
                   exp_w.out_re, out_data.out_re);
          errors++;
        end
        if (exp_w.out_im !== out_data.out_im) begin
          $display("%0t: out_im expected %0d actual %0d", $time,
                   exp_w.out_im, out_data.out_im);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || (pending_q.size() == 0 && weighted_q.size() == 0) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TAPER_START: start_r = val;
      CFG_TAPER_END: end_r = val;
      CFG_FLOOR_HEIGHT: height_r = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_q.size() > 0 || weighted_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_t rand_sample(int radius_hint);
    in_t it;
    int mode;
    it.coord_valid = ($urandom_range(0, 9) != 0);
    it.sample_re = $urandom;
    it.sample_im = $urandom;
    mode = $urandom_range(0, 3);
    if (mode == 0) begin
      it.coord_x = $urandom; it.coord_y = $urandom; it.coord_z = $urandom;
    end else begin
      // mostly near the taper band
      it.coord_x = $signed($urandom_range(0, radius_hint)) * ($urandom_range(0, 1) ? 1 : -1);
      it.coord_y = $signed($urandom_range(0, radius_hint / 2))
                   * ($urandom_range(0, 1) ? 1 : -1);
      it.coord_z = (mode == 3) ? 16'sd0 : $signed($urandom_range(0, radius_hint / 3));
    end
    return it;
  endfunction

  task automatic directed();
    in_t it;
    logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
    for (int i = 0; i < 4; i++) begin
      it.coord_x = ext[i]; it.coord_y = ext[3 - i]; it.coord_z = ext[i];
      it.coord_valid = 1'b1;
      it.sample_re = ext[i]; it.sample_im = ext[(i + 1) % 4];
      pending_q.push_back(it);
    end
    it = '0; it.coord_valid = 1'b0; it.sample_re = 16'sh7fff; it.sample_im = 16'sh8000;
    pending_q.push_back(it);
    for (int r = 0; r < 16; r++) begin
      it = '0;
      it.coord_valid = 1'b1;
      it.coord_x = r * 2048;
      it.sample_re = 16'sh7fff; it.sample_im = 16'sh8000;
      pending_q.push_back(it);
    end
  endtask

  initial begin
    int n;
    logic [15:0] a, b;
    start_r = 16'hffff; end_r = 16'hffff; height_r = HEIGHT_ONE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    settle();

    // normal taper, floor zero
    write_reg(CFG_TAPER_START, 16'd8192);
    write_reg(CFG_TAPER_END, 16'd24576);
    write_reg(CFG_FLOOR_HEIGHT, 16'd0);
    directed();
    for (int i = 0; i < 120; i++) pending_q.push_back(rand_sample(30000));
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    settle();

    // start above end, height saturated above one; unknown index ignored
    write_reg(CFG_TAPER_START, 16'hffff);
    write_reg(CFG_TAPER_END, 16'd100);
    write_reg(CFG_FLOOR_HEIGHT, 16'hffff);
    write_reg(2'd3, 16'h1234);
    for (int i = 0; i < 60; i++) pending_q.push_back(rand_sample(300));
    settle();

    // zero-width extremes
    write_reg(CFG_TAPER_START, 16'd0);
    write_reg(CFG_TAPER_END, 16'd0);
    for (int i = 0; i < 30; i++) pending_q.push_back(rand_sample(4));
    settle();

    // random settings
    for (int ph = 0; ph < 6; ph++) begin
      a = $urandom_range(0, 40000);
      b = a + $urandom_range(1, 65535 - a);
      write_reg(CFG_TAPER_START, a);
      write_reg(CFG_TAPER_END, (ph == 5) ? 16'hffff : b);
      write_reg(CFG_FLOOR_HEIGHT, $urandom_range(0, 32768));
      n = (ph == 5) ? 40 : 45;
      for (int i = 0; i < n; i++) pending_q.push_back(rand_sample(b));
      settle();
    end

    if (errors == 0 && weighted_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
